>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Entry record, cell control group and result status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned PriW = 4;
  localparam int unsigned AgeW = 7;
  localparam int unsigned TagW = 16;
  localparam int unsigned OccW = 5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [AgeW-1:0] age;
    logic [TagW-1:0] tag;
  } entry_t;

  // Per-cell control for one request
  typedef struct packed {
    logic do_ins;     // insert commits this cycle
    logic do_rem;     // removal commits this cycle
    logic occupied;   // cell holds a waiting entry
    logic left_open;  // left neighbor would be displaced by the new entry
  } cell_ctrl_t;

endpackage

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift queue
// Holds one entry; on insert takes the new entry or its left neighbor's, on
// removal takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               open_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // Flag the cell as displaced when it is empty or holds a lower priority
  assign open_o = !ctrl_i.occupied || (entry_q.pri < new_i.pri);

  // Select the next content of the slot
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.do_ins && open_o) begin
      entry_d = ctrl_i.left_open ? left_i : new_i;
    end else if (ctrl_i.do_rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/core/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted queue, highest priority first
// Shift-register queue of CAPACITY cells with stable ordering among equals.
// ----------------------------------------------------------------------------
// The result of each request (insert or remove-head) appears in the output
// register in the cycle after the request is taken. All cells compare their
// priority with the incoming one in parallel and shift one place together,
// so one request per cycle is sustained; the only stall is a held
// result in the output register (in_ready_o low while out_valid_o is high and
// out_ready_i is low). Entries of equal priority leave in arrival order. An
// insert into a full queue returns status full, a removal from an empty queue
// returns status empty; both leave the queue unchanged. occupancy_o gives the
// entry count after the request, modulo 32. No clearing pass after reset.
module stable_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic [spq_pkg::PriW-1:0] priority_req_i,
  input  logic [spq_pkg::AgeW-1:0] age_value_i,
  input  logic [spq_pkg::TagW-1:0] entry_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [spq_pkg::PriW-1:0] out_priority_o,
  output logic [spq_pkg::AgeW-1:0] out_age_o,
  output logic [spq_pkg::TagW-1:0] out_tag_o,
  output logic [spq_pkg::OccW-1:0] occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            fire;
  logic            is_full;
  logic            is_empty;
  logic [CntW-1:0] count_q, count_d;
  entry_t          new_entry;
  entry_t          ent   [CAPACITY];
  logic            open  [CAPACITY];
  cell_ctrl_t      ctrl  [CAPACITY];

  logic            out_valid_q;
  status_e         status_q, status_d;
  entry_t          res_q, res_d;
  logic [OccW-1:0] occ_q, occ_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign new_entry  = '{pri: priority_req_i, age: age_value_i, tag: entry_tag_i};

  // Build the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctrl[i].do_ins    = fire && !req_type_i && !is_full;
    assign ctrl[i].do_rem    = fire && req_type_i && !is_empty;
    assign ctrl[i].occupied  = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign ctrl[i].left_open = 1'b0;
    end else begin : g_body
      assign ctrl[i].left_open = open[i-1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .new_i   (new_entry),
      .left_i  ((i == 0) ? new_entry : ent[(i == 0) ? 0 : i-1]),
      .right_i ((i == CAPACITY-1) ? new_entry : ent[(i == CAPACITY-1) ? i : i+1]),
      .entry_o (ent[i]),
      .open_o  (open[i])
    );
  end

  // Work out the count and the result of the current request
  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    res_d    = '0;
    if (!req_type_i) begin
      if (is_full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        res_d   = ent[0];
        count_d = count_q - CntW'(1);
      end
    end
    occ_d = OccW'(count_d);
  end

  // Hold the count and the valid flag of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = res_q.pri;
  assign out_age_o      = res_q.age;
  assign out_tag_o      = res_q.tag;
  assign occupancy_o    = occ_q;

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // Head holds the highest priority
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (ent[0].pri >= ent[1].pri))
    else $error("head entry out of order");

  // An empty result leaves the queue empty
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_EMPTY) |-> (occ_q == '0))
    else $error("empty status with nonzero occupancy");

  // A full result reports the full count
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> (occ_q == OccW'(CAPACITY)))
    else $error("full status with wrong occupancy");

  // Without an accepted request the entry count stays unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("count changed without a request");

endmodule
